// ----- rtl/u8u2_pkg.sv -----
// Shared types and codes for the UTF-8 to UCS-2 decoder.
// Used by u8u2_step and utf8_to_ucs2_decoder; depends on nothing.
`timescale 1ns / 1ps

package u8u2_pkg;

  // Decoder phase: what the next byte is expected to be.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LAST    = 2'd1,
    PH_MIDDLE  = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Largest output byte count before saturation.
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [15:0] COUNT_LAST_ADD = 16'hFFFD;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    phase_t      phase;
    logic [9:0]  partial_bits;
    logic [15:0] out_count;
  } dec_state_t;

  // One result, with a flag saying whether the byte produced one.
  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic [1:0]  kind;
    logic [15:0] byte_total;
  } dec_result_t;

endpackage

// ----- rtl/u8u2_step.sv -----
// Combinational decode of one byte against the current decoder state.
// Depends on u8u2_pkg for the state and result types.
`timescale 1ns / 1ps

module u8u2_step (
  input  u8u2_pkg::dec_state_t  cur,
  input  logic [7:0]            in_byte,
  output u8u2_pkg::dec_state_t  nxt,
  output u8u2_pkg::dec_result_t res
);

  logic        is_zero;
  logic        is_cont;
  logic [15:0] count_inc;

  assign is_zero = (in_byte == 8'h00);
  assign is_cont = (in_byte[7:6] == 2'b10);

  // Saturating count of output bytes, two per character.
  assign count_inc = (cur.out_count <= u8u2_pkg::COUNT_LAST_ADD) ?
                     cur.out_count + 16'd2 : u8u2_pkg::COUNT_MAX;

  // Next state.
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      u8u2_pkg::PH_IDLE: begin
        if (is_zero) begin
          nxt.out_count    = 16'd0;
          nxt.partial_bits = 10'd0;
        end else if (in_byte[7] == 1'b0) begin
          nxt.out_count = count_inc;
        end else if (in_byte[7:5] == 3'b110) begin
          nxt.partial_bits = {5'd0, in_byte[4:0]};
          nxt.phase        = u8u2_pkg::PH_LAST;
        end else if (in_byte[7:4] == 4'b1110) begin
          nxt.partial_bits = {6'd0, in_byte[3:0]};
          nxt.phase        = u8u2_pkg::PH_MIDDLE;
        end else begin
          nxt.out_count    = 16'd0;
          nxt.partial_bits = 10'd0;
          nxt.phase        = u8u2_pkg::PH_DISCARD;
        end
      end
      u8u2_pkg::PH_LAST, u8u2_pkg::PH_MIDDLE: begin
        if (!is_cont) begin
          // A zero byte here ends the string as well as being an error.
          nxt.out_count    = 16'd0;
          nxt.partial_bits = 10'd0;
          nxt.phase        = is_zero ? u8u2_pkg::PH_IDLE : u8u2_pkg::PH_DISCARD;
        end else if (cur.phase == u8u2_pkg::PH_MIDDLE) begin
          nxt.partial_bits = {cur.partial_bits[3:0], in_byte[5:0]};
          nxt.phase        = u8u2_pkg::PH_LAST;
        end else begin
          nxt.out_count    = count_inc;
          nxt.partial_bits = 10'd0;
          nxt.phase        = u8u2_pkg::PH_IDLE;
        end
      end
      u8u2_pkg::PH_DISCARD: begin
        if (is_zero) begin
          nxt.out_count    = 16'd0;
          nxt.partial_bits = 10'd0;
          nxt.phase        = u8u2_pkg::PH_IDLE;
        end
      end
      default: nxt = cur;
    endcase
  end

  // Result for this byte, if any.
  always_comb begin
    res = '0;
    unique case (cur.phase)
      u8u2_pkg::PH_IDLE: begin
        res.emit = 1'b1;
        if (is_zero) begin
          res.kind       = u8u2_pkg::KIND_END;
          res.byte_total = cur.out_count;
        end else if (in_byte[7] == 1'b0) begin
          res.kind      = u8u2_pkg::KIND_CHAR;
          res.code_unit = {8'd0, in_byte};
        end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110) begin
          res.emit = 1'b0;
        end else begin
          res.kind = u8u2_pkg::KIND_ERROR;
        end
      end
      u8u2_pkg::PH_LAST, u8u2_pkg::PH_MIDDLE: begin
        if (!is_cont) begin
          res.emit = 1'b1;
          res.kind = u8u2_pkg::KIND_ERROR;
        end else if (cur.phase == u8u2_pkg::PH_LAST) begin
          res.emit      = 1'b1;
          res.kind      = u8u2_pkg::KIND_CHAR;
          res.code_unit = {cur.partial_bits, in_byte[5:0]};
        end
      end
      u8u2_pkg::PH_DISCARD: res = '0;
      default: res = '0;
    endcase
  end

endmodule

// ----- rtl/utf8_to_ucs2_decoder.sv -----
// Top level of the UTF-8 to UCS-2 decoder: state register, output register and skid stage.
// Depends on u8u2_pkg and u8u2_step.
`timescale 1ns / 1ps

// The decoder takes one UTF-8 byte per cycle while byte_stall is low and gives at most one
// result per byte: a 16-bit code unit when a 1-, 2- or 3-byte sequence completes, an end
// result with the saturating output byte count on a terminating zero, or an error result
// on a bad lead or continuation byte, after which bytes are dropped up to the next zero.
// Decoding is a single combinational pass from the phase register into the output
// register, or the skid stage while that is held; the sustained rate is one byte per
// cycle while the consumer does not stall. The skid stage keeps the byte side open for
// one further result while the consumer stalls; byte_stall rises only once both are full.
module utf8_to_ucs2_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  in_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] code_unit,
  output logic [1:0]  kind,
  output logic [15:0] byte_total
);

  u8u2_pkg::dec_state_t  state;
  u8u2_pkg::dec_state_t  state_next;
  u8u2_pkg::dec_result_t step_res;
  u8u2_pkg::dec_result_t out_reg;
  u8u2_pkg::dec_result_t skid;
  logic                  skid_valid;
  logic                  in_take;
  logic                  out_take;

  assign in_take    = byte_valid && !byte_stall;
  assign out_take   = result_valid && !result_stall;
  assign byte_stall = skid_valid;

  u8u2_step u_step (
    .cur     (state),
    .in_byte (in_byte),
    .nxt     (state_next),
    .res     (step_res)
  );

  // Decoder state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= u8u2_pkg::PH_IDLE;
      state.partial_bits <= 10'd0;
      state.out_count    <= 16'd0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Output register and skid stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (skid_valid) begin
        // No new transaction can arrive while the skid stage is full.
        if (out_take) begin
          out_reg    <= skid;
          skid_valid <= 1'b0;
        end
      end else if (in_take && step_res.emit) begin
        if (!result_valid || out_take) begin
          out_reg      <= step_res;
          result_valid <= 1'b1;
        end else begin
          skid       <= step_res;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign code_unit  = out_reg.code_unit;
  assign kind       = out_reg.kind;
  assign byte_total = out_reg.byte_total;

  // The skid stage only fills behind a waiting result.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid stage full with output register empty");

  // A drained output register with a full skid stage is refilled next cycle.
  a_skid_drains : assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !result_stall) |=> (!skid_valid && result_valid))
    else $error("skid stage did not drain into output register");

  // Nonzero bytes while discarding keep the decoder discarding.
  a_discard_holds : assert property (@(posedge clk) disable iff (rst)
    (in_take && state.phase == u8u2_pkg::PH_DISCARD && in_byte != 8'h00)
    |=> (state.phase == u8u2_pkg::PH_DISCARD))
    else $error("discard phase left on a nonzero byte");

  // Only end results carry a byte count.
  a_total_only_on_end : assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind != u8u2_pkg::KIND_END) |-> (byte_total == 16'd0))
    else $error("byte count on a result that is not an end result");

endmodule
